### design/rfe_pkg.sv
// Shared types, constants and microcode table for the rail fence encryptor.
`default_nettype none

package rfe_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int BYTE_W      = 8;
    localparam int RAIL_W      = 7;
    localparam int UPC_W       = 3;

    localparam logic [RAIL_W-1:0] RAIL_RESET = RAIL_W'(3);

    typedef struct packed {
        logic [BYTE_W-1:0] plain_byte;
        logic              is_last;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] cipher_byte;
        logic              last_out;
        logic              overflow;
    } t_out_item;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SETUP,
        OP_RAIL,
        OP_READ,
        OP_EMIT,
        OP_NEXT,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } t_wait;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_LAST,
        COND_POS_IN,
        COND_MORE_RAILS
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_wait wt;
        t_cond cond;
        t_upc  target;
    } t_ucode;

    localparam t_upc UPC_LOAD  = UPC_W'(0);
    localparam t_upc UPC_SETUP = UPC_W'(1);
    localparam t_upc UPC_RAIL  = UPC_W'(2);
    localparam t_upc UPC_READ  = UPC_W'(3);
    localparam t_upc UPC_EMIT  = UPC_W'(4);
    localparam t_upc UPC_NEXT  = UPC_W'(5);
    localparam t_upc UPC_FIN   = UPC_W'(6);

    // Control program: load, set up, then per rail read/emit until the rail runs out.
    function automatic t_ucode ucode(input t_upc upc);
        t_ucode w;
        w = '{op: OP_NOP, wt: WAIT_NONE, cond: COND_ALWAYS, target: UPC_LOAD};
        unique case (upc)
            UPC_LOAD:  w = '{op: OP_LOAD,   wt: WAIT_IN,   cond: COND_NOT_LAST,
                            target: UPC_LOAD};
            UPC_SETUP: w = '{op: OP_SETUP,  wt: WAIT_NONE, cond: COND_NEVER,
                            target: UPC_LOAD};
            UPC_RAIL:  w = '{op: OP_RAIL,   wt: WAIT_NONE, cond: COND_NEVER,
                            target: UPC_LOAD};
            UPC_READ:  w = '{op: OP_READ,   wt: WAIT_NONE, cond: COND_NEVER,
                            target: UPC_LOAD};
            UPC_EMIT:  w = '{op: OP_EMIT,   wt: WAIT_OUT,  cond: COND_POS_IN,
                            target: UPC_READ};
            UPC_NEXT:  w = '{op: OP_NEXT,   wt: WAIT_NONE, cond: COND_MORE_RAILS,
                            target: UPC_RAIL};
            UPC_FIN:   w = '{op: OP_FINISH, wt: WAIT_NONE, cond: COND_ALWAYS,
                            target: UPC_LOAD};
            default:   w = '{op: OP_NOP,    wt: WAIT_NONE, cond: COND_ALWAYS,
                            target: UPC_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### design/rfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/rail_fence_encrypt_top.sv
// Rail fence encryptor top level: message buffer, microcoded sequencer and output register.
`default_nettype none

// Bytes of a message are taken one per cycle while the sequencer is loading, into a
// MAX_LEN-byte buffer until the word marked last; bytes beyond MAX_LEN are dropped and
// flag overflow on every output word of that message. The ciphertext for the rail count
// in force at setup then comes out rail by rail. A seven-step microprogram drives the
// datapath: each output byte takes a buffer read, then an output load; each rail adds
// a rail start and a rail advance; and a message adds a setup and a wrap-up. The rail
// loop runs once when the text passes unchanged.
// No new byte is taken while a message is being emitted. The rail count register
// may be written at any time the block is idle; zero acts as one rail.

module rail_fence_encrypt_top #(
    parameter int MAX_LEN = rfe_pkg::MAX_LEN_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire rfe_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output rfe_pkg::t_out_item              o_out_data,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [rfe_pkg::RAIL_W-1:0] i_cfg_data
);

    import rfe_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int SW    = LEN_W + 1;
    localparam int PW    = LEN_W + 2;
    localparam int CW    = (RAIL_W > LEN_W) ? RAIL_W : LEN_W;

    // control registers
    t_upc              r_upc,        n_upc;
    logic [LEN_W-1:0]  r_len,        n_len;
    logic              r_ovf,        n_ovf;
    logic [RAIL_W-1:0] r_rail_count, n_rail_count;
    logic              r_out_valid,  n_out_valid;

    // datapath registers
    logic [LEN_W-1:0]  r_rmax,   n_rmax;
    logic [SW-1:0]     r_period, n_period;
    logic [LEN_W-1:0]  r_rails,  n_rails;
    logic [LEN_W-1:0]  r_rail,   n_rail;
    logic [PW-1:0]     r_pos,    n_pos;
    logic              r_phase,  n_phase;
    logic [SW-1:0]     r_step_a, n_step_a;
    logic [SW-1:0]     r_step_b, n_step_b;
    logic [LEN_W-1:0]  r_cnt,    n_cnt;
    t_out_item         r_out,    n_out;

    t_ucode            uw;
    logic              in_accept;
    logic              out_free;
    logic              advance;
    logic              cond_hit;
    logic              fence;
    logic              rail_edge;
    logic [SW-1:0]     two_r;
    logic [SW-1:0]     cur_step;
    logic [PW-1:0]     pos_next;
    logic [LEN_W-1:0]  rail_next;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    rfe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LEN)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_in_data.plain_byte),
        .i_re    (ram_re),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign uw          = ucode(r_upc);
    assign o_in_ready  = (uw.op == OP_LOAD);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign ram_we = in_accept && (r_len < LEN_W'(MAX_LEN));
    assign ram_re = (uw.op == OP_READ);

    // Fence only when 2 <= rails < length; otherwise the text passes unchanged.
    assign fence     = (r_rail_count >= RAIL_W'(2)) && (CW'(r_rail_count) < CW'(r_len));
    assign rail_edge = (r_rail == '0) || (r_rail == r_rmax);
    assign two_r     = {r_rail, 1'b0};
    assign cur_step  = r_phase ? r_step_b : r_step_a;
    assign pos_next  = r_pos + PW'(cur_step);
    assign rail_next = r_rail + LEN_W'(1);

    always_comb begin
        unique case (uw.cond)
            COND_NEVER:      cond_hit = 1'b0;
            COND_ALWAYS:     cond_hit = 1'b1;
            COND_NOT_LAST:   cond_hit = !i_in_data.is_last;
            COND_POS_IN:     cond_hit = (pos_next < PW'(r_len));
            COND_MORE_RAILS: cond_hit = (rail_next < r_rails);
            default:         cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        unique case (uw.wt)
            WAIT_NONE: advance = 1'b1;
            WAIT_IN:   advance = in_accept;
            WAIT_OUT:  advance = out_free;
            default:   advance = 1'b1;
        endcase
    end

    always_comb begin
        n_upc        = r_upc;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_rail_count = r_rail_count;
        n_out_valid  = r_out_valid;
        n_rmax       = r_rmax;
        n_period     = r_period;
        n_rails      = r_rails;
        n_rail       = r_rail;
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_step_a     = r_step_a;
        n_step_b     = r_step_b;
        n_cnt        = r_cnt;
        n_out        = r_out;

        if (i_cfg_valid) begin
            n_rail_count = i_cfg_data;
        end

        // drop the output word once it is taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (advance) begin
            n_upc = cond_hit ? uw.target : r_upc + UPC_W'(1);
        end

        unique case (uw.op)
            OP_LOAD: begin
                if (in_accept) begin
                    if (r_len < LEN_W'(MAX_LEN)) begin
                        n_len = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            OP_SETUP: begin
                n_rail = '0;
                n_cnt  = '0;
                n_rmax = LEN_W'(r_rail_count - RAIL_W'(1));
                if (fence) begin
                    n_rails  = LEN_W'(r_rail_count);
                    n_period = {LEN_W'(r_rail_count - RAIL_W'(1)), 1'b0};
                end else begin
                    n_rails  = LEN_W'(1);
                    n_period = '0;
                end
            end
            OP_RAIL: begin
                n_pos   = PW'(r_rail);
                n_phase = 1'b0;
                if (r_period == '0) begin
                    n_step_a = SW'(1);
                    n_step_b = SW'(1);
                end else if (rail_edge) begin
                    n_step_a = r_period;
                    n_step_b = r_period;
                end else begin
                    n_step_a = r_period - two_r;
                    n_step_b = two_r;
                end
            end
            OP_READ: begin
                n_pos = r_pos;
            end
            OP_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.cipher_byte = ram_rdata;
                    n_out.last_out    = (r_cnt + LEN_W'(1)) == r_len;
                    n_out.overflow    = r_ovf;
                    n_cnt             = r_cnt + LEN_W'(1);
                    n_pos             = pos_next;
                    n_phase           = !r_phase;
                end
            end
            OP_NEXT: begin
                n_rail = rail_next;
            end
            OP_FINISH: begin
                n_len = '0;
                n_ovf = 1'b0;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc        <= UPC_LOAD;
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_rail_count <= RAIL_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_upc        <= n_upc;
            r_len        <= n_len;
            r_ovf        <= n_ovf;
            r_rail_count <= n_rail_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rmax   <= n_rmax;
        r_period <= n_period;
        r_rails  <= n_rails;
        r_rail   <= n_rail;
        r_pos    <= n_pos;
        r_phase  <= n_phase;
        r_step_a <= n_step_a;
        r_step_b <= n_step_b;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire
